[design/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion wrappers shared by the clipper RTL; empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// checked outside reset
`define LSRC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// checked on every edge, reset included
`define LSRC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define LSRC_ASSERT(lbl, prop, msg)
`define LSRC_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

[design/lsrc_pkg.sv]
// ----------------------------------------------------------------------------
// lsrc_pkg
// Types and constants of the line segment rectangle clipper.
// ----------------------------------------------------------------------------
`default_nettype none

package lsrc_pkg;

  // coordinate width
  localparam int COORD_BITS = 16;
  localparam int CW         = COORD_BITS;
  localparam int PW         = 2 * CW;

  // front to back queue
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  typedef logic signed [CW-1:0] coord_t;
  typedef logic signed [CW:0]   diff_t;
  typedef logic        [CW-1:0] mag_t;
  typedef logic        [PW-1:0] prod_t;

  // register indexes
  typedef enum logic [1:0] {
    CFG_LEFT   = 2'd0,
    CFG_TOP    = 2'd1,
    CFG_RIGHT  = 2'd2,
    CFG_BOTTOM = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    coord_t start_x;
    coord_t start_y;
    coord_t end_x;
    coord_t end_y;
  } seg_word_t;

  typedef struct packed {
    logic   visible;
    coord_t clipped_start_x;
    coord_t clipped_start_y;
    coord_t clipped_end_x;
    coord_t clipped_end_y;
  } res_word_t;

  typedef struct packed {
    coord_t left;
    coord_t top;
    coord_t right;
    coord_t bottom;
  } rect_t;

  // segment in flight
  typedef struct packed {
    logic   vis;
    logic   xinc;
    logic   yinc;
    coord_t x1;
    coord_t y1;
    coord_t x2;
    coord_t y2;
  } item_t;

  // one intersection request
  typedef struct packed {
    logic   op;
    coord_t o0;
    coord_t o1;
    coord_t a0;
    coord_t a1;
    coord_t bound;
  } xreq_t;

endpackage

`default_nettype wire

[design/lsrc_fifo.sv]
// ----------------------------------------------------------------------------
// lsrc_fifo
// Short flop queue between classification and the clipping pipeline.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module lsrc_fifo import lsrc_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t push_data,
  output logic  full,
  input  logic  pop,
  output logic  head_valid,
  output item_t head
);

  localparam logic [QAW:0] QFULL = (QAW+1)'(QDEPTH);
  localparam logic [QAW:0] CNT1  = (QAW+1)'(1);

  item_t          mem [QDEPTH];
  logic [QAW:0]   count;
  logic [QAW-1:0] wr_ptr;
  logic [QAW-1:0] rd_ptr;

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      wr_ptr <= '0;
      rd_ptr <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + QAW'(1);
      if (pop)  rd_ptr <= rd_ptr + QAW'(1);
      if (push && !pop) count <= count + CNT1;
      else if (pop && !push) count <= count - CNT1;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_data;
  end

  assign full       = (count == QFULL);
  assign head_valid = (count != '0);
  assign head       = mem[rd_ptr];

  `LSRC_ASSERT(a_fifo_cnt_range, count <= QFULL, "queue count over depth")
  `LSRC_ASSERT(a_fifo_cnt_up, push && !pop |=> count == $past(count) + CNT1, "queue count lost a push")
  `LSRC_ASSERT_ALWAYS(a_fifo_rst_empty, rst |=> !head_valid, "queue not empty after reset")

endmodule

`default_nettype wire

[design/lsrc_front.sv]
// ----------------------------------------------------------------------------
// lsrc_front
// Takes segment words, does the trivial reject test and queues them.
// ----------------------------------------------------------------------------
`default_nettype none

module lsrc_front import lsrc_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  rect_t     rect,
  input  logic      seg_valid,
  output logic      seg_ready,
  input  seg_word_t seg,
  input  logic      pop,
  output logic      head_valid,
  output item_t     head
);

  item_t cls;
  logic  full;

  // classify: both ends past one edge means reject
  always_comb begin
    cls.x1   = seg.start_x;
    cls.y1   = seg.start_y;
    cls.x2   = seg.end_x;
    cls.y2   = seg.end_y;
    cls.vis  = !((seg.start_x < rect.left   && seg.end_x < rect.left)   ||
                 (seg.start_y < rect.top    && seg.end_y < rect.top)    ||
                 (seg.start_x > rect.right  && seg.end_x > rect.right)  ||
                 (seg.start_y > rect.bottom && seg.end_y > rect.bottom));
    cls.xinc = (seg.start_x < seg.end_x);
    cls.yinc = 1'b0;
  end

  assign seg_ready = !full;

  lsrc_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (seg_valid && !full),
    .push_data  (cls),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

endmodule

`default_nettype wire

[design/lsrc_cross.sv]
// ----------------------------------------------------------------------------
// lsrc_cross
// Pipelined intersection: o0 + (bound - a0) * (o1 - o0) / (a1 - a0),
// truncated toward zero and saturated; one quotient bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module lsrc_cross import lsrc_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   adv,
  input  logic   in_valid,
  input  xreq_t  req,
  input  item_t  in_item,
  output logic   out_valid,
  output logic   out_op,
  output coord_t out_edge,
  output coord_t out_res,
  output item_t  out_item
);

  localparam longint CMAX = (longint'(1) <<< (CW-1)) - longint'(1);
  localparam logic signed [PW+1:0] SMAX = (PW+2)'(CMAX);
  localparam logic signed [PW+1:0] SMIN = -SMAX - (PW+2)'(1);

  typedef struct packed {
    logic   op;
    item_t  item;
    coord_t o0;
    coord_t bound;
    diff_t  num;
    diff_t  d;
    diff_t  den;
  } pre_t;

  typedef struct packed {
    logic   op;
    item_t  item;
    coord_t o0;
    coord_t bound;
    logic   neg;
    logic   zero;
    mag_t   dvsr;
    mag_t   rem;
    prod_t  dq;
  } dstage_t;

  function automatic mag_t mag_of(diff_t v);
    diff_t n;
    n = -v;
    return v[CW] ? n[CW-1:0] : v[CW-1:0];
  endfunction

  // one restoring division step
  function automatic dstage_t div_step(dstage_t s);
    logic [CW:0] sh;
    logic [CW:0] dz;
    logic [CW:0] tmp;
    logic        ge;
    dstage_t     r;
    r   = s;
    sh  = {s.rem, s.dq[PW-1]};
    dz  = {1'b0, s.dvsr};
    tmp = sh - dz;
    ge  = (sh >= dz);
    r.dq  = {s.dq[PW-2:0], ge};
    r.rem = ge ? tmp[CW-1:0] : sh[CW-1:0];
    return r;
  endfunction

  logic                  pre_v;
  pre_t                  pre;
  dstage_t               ld;
  logic [PW:0]           dvv;
  dstage_t               dv [PW+1];
  logic signed [PW+1:0]  o0w;
  logic signed [PW+1:0]  qw;
  logic signed [PW+1:0]  sum;
  coord_t                res_next;

  // stage 0: differences
  always_ff @(posedge clk) begin
    if (rst) pre_v <= 1'b0;
    else if (adv) pre_v <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pre.op    <= req.op;
      pre.item  <= in_item;
      pre.o0    <= req.o0;
      pre.bound <= req.bound;
      pre.num   <= diff_t'(req.bound) - diff_t'(req.a0);
      pre.d     <= diff_t'(req.o1) - diff_t'(req.o0);
      pre.den   <= diff_t'(req.a1) - diff_t'(req.a0);
    end
  end

  // stage 1: sign, magnitudes and product
  always_comb begin
    ld.op    = pre.op;
    ld.item  = pre.item;
    ld.o0    = pre.o0;
    ld.bound = pre.bound;
    ld.neg   = pre.num[CW] ^ pre.d[CW] ^ pre.den[CW];
    ld.zero  = (pre.den == '0);
    ld.dvsr  = mag_of(pre.den);
    ld.rem   = '0;
    ld.dq    = prod_t'(mag_of(pre.num)) * prod_t'(mag_of(pre.d));
  end

  // divider stages
  always_ff @(posedge clk) begin
    if (rst) dvv <= '0;
    else if (adv) dvv <= {dvv[PW-1:0], pre_v};
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dv[0] <= ld;
      for (int k = 0; k < PW; k++) begin
        dv[k+1] <= div_step(dv[k]);
      end
    end
  end

  // apply sign, saturate; zero divisor keeps o0
  always_comb begin
    o0w = (PW+2)'(dv[PW].o0);
    qw  = signed'({2'b00, dv[PW].dq});
    sum = dv[PW].neg ? (o0w - qw) : (o0w + qw);
    if (dv[PW].zero)   res_next = dv[PW].o0;
    else if (sum > SMAX) res_next = coord_t'(SMAX);
    else if (sum < SMIN) res_next = coord_t'(SMIN);
    else               res_next = coord_t'(sum);
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (adv) out_valid <= dvv[PW];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_op   <= dv[PW].op;
      out_edge <= dv[PW].bound;
      out_res  <= res_next;
      out_item <= dv[PW].item;
    end
  end

endmodule

`default_nettype wire

[design/lsrc_back.sv]
// ----------------------------------------------------------------------------
// lsrc_back
// Clipping pipeline: x clips, second reject test, y clips, result register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module lsrc_back import lsrc_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  rect_t     rect,
  input  logic      head_valid,
  input  item_t     head,
  output logic      pop,
  output logic      res_valid,
  input  logic      res_ready,
  output res_word_t res
);

  logic   adv;
  xreq_t  r1, r2, r3, r4;
  logic   v1, v2, v3, v4;
  logic   op1, op2, op3, op4;
  coord_t e1, e2, e3, e4;
  coord_t q1, q2, q3, q4;
  item_t  i1, i2, i3, i4;
  item_t  u1, u2, u3, u4;
  res_word_t res_next;

  // whole pipeline moves unless the result word is stuck
  assign adv = !res_valid || res_ready;
  assign pop = head_valid && adv;

  // first endpoint along x
  always_comb begin
    r1.op    = head.vis && (head.xinc ? (head.x1 < rect.left) : (head.x1 > rect.right));
    r1.bound = head.xinc ? rect.left : rect.right;
    r1.o0    = head.y1;
    r1.o1    = head.y2;
    r1.a0    = head.x1;
    r1.a1    = head.x2;
  end

  lsrc_cross u_x1 (
    .clk(clk), .rst(rst), .adv(adv), .in_valid(head_valid), .req(r1), .in_item(head),
    .out_valid(v1), .out_op(op1), .out_edge(e1), .out_res(q1), .out_item(i1)
  );

  // second endpoint along x
  always_comb begin
    u1 = i1;
    if (op1) begin
      u1.y1 = q1;
      u1.x1 = e1;
    end
    r2.op    = u1.vis && (u1.xinc ? (u1.x2 > rect.right) : (u1.x2 < rect.left));
    r2.bound = u1.xinc ? rect.right : rect.left;
    r2.o0    = u1.y1;
    r2.o1    = u1.y2;
    r2.a0    = u1.x1;
    r2.a1    = u1.x2;
  end

  lsrc_cross u_x2 (
    .clk(clk), .rst(rst), .adv(adv), .in_valid(v1), .req(r2), .in_item(u1),
    .out_valid(v2), .out_op(op2), .out_edge(e2), .out_res(q2), .out_item(i2)
  );

  // second reject test, then first endpoint along y
  always_comb begin
    u2 = i2;
    if (op2) begin
      u2.y2 = q2;
      u2.x2 = e2;
    end
    u2.vis  = u2.vis && !((u2.y1 < rect.top && u2.y2 < rect.top) ||
                          (u2.y1 > rect.bottom && u2.y2 > rect.bottom));
    u2.yinc = (u2.y1 < u2.y2);
    r3.op    = u2.vis && (u2.yinc ? (u2.y1 < rect.top) : (u2.y1 > rect.bottom));
    r3.bound = u2.yinc ? rect.top : rect.bottom;
    r3.o0    = u2.x1;
    r3.o1    = u2.x2;
    r3.a0    = u2.y1;
    r3.a1    = u2.y2;
  end

  lsrc_cross u_y1 (
    .clk(clk), .rst(rst), .adv(adv), .in_valid(v2), .req(r3), .in_item(u2),
    .out_valid(v3), .out_op(op3), .out_edge(e3), .out_res(q3), .out_item(i3)
  );

  // second endpoint along y
  always_comb begin
    u3 = i3;
    if (op3) begin
      u3.x1 = q3;
      u3.y1 = e3;
    end
    r4.op    = u3.vis && (u3.yinc ? (u3.y2 > rect.bottom) : (u3.y2 < rect.top));
    r4.bound = u3.yinc ? rect.bottom : rect.top;
    r4.o0    = u3.x1;
    r4.o1    = u3.x2;
    r4.a0    = u3.y1;
    r4.a1    = u3.y2;
  end

  lsrc_cross u_y2 (
    .clk(clk), .rst(rst), .adv(adv), .in_valid(v3), .req(r4), .in_item(u3),
    .out_valid(v4), .out_op(op4), .out_edge(e4), .out_res(q4), .out_item(i4)
  );

  // result word, zeroed on reject
  always_comb begin
    u4 = i4;
    if (op4) begin
      u4.x2 = q4;
      u4.y2 = e4;
    end
    res_next.visible         = u4.vis;
    res_next.clipped_start_x = u4.vis ? u4.x1 : '0;
    res_next.clipped_start_y = u4.vis ? u4.y1 : '0;
    res_next.clipped_end_x   = u4.vis ? u4.x2 : '0;
    res_next.clipped_end_y   = u4.vis ? u4.y2 : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) res_valid <= 1'b0;
    else if (adv) res_valid <= v4;
  end

  always_ff @(posedge clk) begin
    if (adv) res <= res_next;
  end

  `LSRC_ASSERT(a_back_reject_zero, res_valid && !res.visible |-> res.clipped_start_x == '0 && res.clipped_start_y == '0 && res.clipped_end_x == '0 && res.clipped_end_y == '0, "rejected word not zeroed")

endmodule

`default_nettype wire

[design/line_segment_rect_clipper_top.sv]
// Path: an accepted segment passes through the four bit-per-stage intersection dividers
//   in series and then the result register before it leaves as a result word.
// Throughput: one segment per cycle while result words are taken; a 4-word queue decouples
//   intake from the clipping pipeline, which stalls only while the result word waits.
// Reset: synchronous, clears all valid state; rectangle returns to 0,0 .. 1023,767.
// ----------------------------------------------------------------------------
// line_segment_rect_clipper_top
// Clips line segments against a programmable rectangle.
// ----------------------------------------------------------------------------
`default_nettype none

module line_segment_rect_clipper_top import lsrc_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  cfg_idx_t  cfg_index,
  input  coord_t    cfg_data,
  input  logic      seg_valid,
  output logic      seg_ready,
  input  seg_word_t seg,
  output logic      res_valid,
  input  logic      res_ready,
  output res_word_t res
);

  rect_t rect;
  logic  head_valid;
  item_t head;
  logic  pop;

  assign cfg_ready = 1'b1;

  // rectangle registers
  always_ff @(posedge clk) begin
    if (rst) begin
      rect.left   <= coord_t'(0);
      rect.top    <= coord_t'(0);
      rect.right  <= coord_t'(1023);
      rect.bottom <= coord_t'(767);
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_LEFT:   rect.left   <= cfg_data;
        CFG_TOP:    rect.top    <= cfg_data;
        CFG_RIGHT:  rect.right  <= cfg_data;
        CFG_BOTTOM: rect.bottom <= cfg_data;
        default:    rect.left   <= rect.left;
      endcase
    end
  end

  lsrc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .rect       (rect),
    .seg_valid  (seg_valid),
    .seg_ready  (seg_ready),
    .seg        (seg),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  lsrc_back u_back (
    .clk        (clk),
    .rst        (rst),
    .rect       (rect),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res)
  );

endmodule

`default_nettype wire
